/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies another in the same cycle
`define JCTP_ASSERT_SAME(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// condition implies another in the following cycle
`define JCTP_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/jctp_pkg.sv */
package jctp_pkg;

  localparam int MAX_STATES = 64;
  localparam int NUM_TERMS  = 12;
  // register stages from input transfer to the back end output register
  localparam int LAT        = 4 + 3 * NUM_TERMS + 5;

  localparam logic [6:0]  CNT_RESET = 7'd4;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [36:0] LN2_X32   = 37'd95265423104;
  localparam logic [37:0] TWO37     = 38'h20_0000_0000;
  // reciprocal of ln2 for the range reduction estimate
  localparam logic [5:0]  KRCP      = 6'(TWO37 / 38'd2977044472);

  localparam logic [34:0] TWO33 = 35'h2_0000_0000;

  // floor(2^33 / m), m from 1 up to the largest state count
  localparam logic [33:0] RECIP [0:64] = '{
    34'd0,
    34'(TWO33 / 1),  34'(TWO33 / 2),  34'(TWO33 / 3),  34'(TWO33 / 4),
    34'(TWO33 / 5),  34'(TWO33 / 6),  34'(TWO33 / 7),  34'(TWO33 / 8),
    34'(TWO33 / 9),  34'(TWO33 / 10), 34'(TWO33 / 11), 34'(TWO33 / 12),
    34'(TWO33 / 13), 34'(TWO33 / 14), 34'(TWO33 / 15), 34'(TWO33 / 16),
    34'(TWO33 / 17), 34'(TWO33 / 18), 34'(TWO33 / 19), 34'(TWO33 / 20),
    34'(TWO33 / 21), 34'(TWO33 / 22), 34'(TWO33 / 23), 34'(TWO33 / 24),
    34'(TWO33 / 25), 34'(TWO33 / 26), 34'(TWO33 / 27), 34'(TWO33 / 28),
    34'(TWO33 / 29), 34'(TWO33 / 30), 34'(TWO33 / 31), 34'(TWO33 / 32),
    34'(TWO33 / 33), 34'(TWO33 / 34), 34'(TWO33 / 35), 34'(TWO33 / 36),
    34'(TWO33 / 37), 34'(TWO33 / 38), 34'(TWO33 / 39), 34'(TWO33 / 40),
    34'(TWO33 / 41), 34'(TWO33 / 42), 34'(TWO33 / 43), 34'(TWO33 / 44),
    34'(TWO33 / 45), 34'(TWO33 / 46), 34'(TWO33 / 47), 34'(TWO33 / 48),
    34'(TWO33 / 49), 34'(TWO33 / 50), 34'(TWO33 / 51), 34'(TWO33 / 52),
    34'(TWO33 / 53), 34'(TWO33 / 54), 34'(TWO33 / 55), 34'(TWO33 / 56),
    34'(TWO33 / 57), 34'(TWO33 / 58), 34'(TWO33 / 59), 34'(TWO33 / 60),
    34'(TWO33 / 61), 34'(TWO33 / 62), 34'(TWO33 / 63), 34'(TWO33 / 64)
  };

  // series state handed from cell to cell
  typedef struct packed {
    logic [32:0]        term;
    logic signed [34:0] sum;
    logic [31:0]        r;
    logic [4:0]         k;
    logic               zero;
    logic               eq;
  } exp_t;

  typedef struct packed {
    logic [31:0] d2;
    logic [31:0] d1;
    logic [30:0] p;
  } res_t;

endpackage

/* sv/jukes_cantor_transition_probability_core.sv */
// Jukes-Cantor transition probability with first and second time derivatives.
// Input channel in_*: one transfer carries a branch time (unsigned Q8.24) and
// a pair of state indices; the result channel out_* returns probability and
// the two derivatives in Q2.30, one result for every input transfer, in order.
// cfg_we/cfg_wdata set the state count N (clamped to 2..64, reset value 4);
// write it only while no transfer is in flight.
// Throughput: one transfer per cycle while in_tready is high. The pipeline
// from the input transfer to out_tvalid has 4 stages of time scaling and
// range reduction, a chain of 12 series cells of 3 stages each (multiply,
// reciprocal divide, correct and accumulate) and 5 output stages.
// Reset clears all valid flags and sets N to 4; the pipeline is then empty.
// When the receiver stalls, a result waits in the output register and the
// next one lands in a skid register; only while both are full is the whole
// pipeline frozen and in_tready low.
`include "assert_macros.svh"
module jukes_cantor_transition_probability_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // branch_time [31:0], from_state [37:32], to_state [43:38], zero fill
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // probability [30:0], first_derivative [62:31], second_derivative [94:63], zero fill
  output logic [95:0] out_tdata,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int LAST = jctp_pkg::LAT - 1;

  logic [6:0]     n_r;
  logic           en;
  logic [LAST:0]  vld_r;
  logic           out_valid_r;
  logic           skid_full_r;
  jctp_pkg::res_t out_data_r;
  jctp_pkg::res_t skid_data_r;
  jctp_pkg::res_t res;
  jctp_pkg::exp_t chain [0:jctp_pkg::NUM_TERMS];
  logic           take;
  logic           arrive;

  // state count register, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= jctp_pkg::CNT_RESET;
    end else if (cfg_we) begin
      if (cfg_wdata < 7'd2) begin
        n_r <= 7'd2;
      end else if (cfg_wdata > 7'(jctp_pkg::MAX_STATES)) begin
        n_r <= 7'(jctp_pkg::MAX_STATES);
      end else begin
        n_r <= cfg_wdata;
      end
    end
  end

  assign en        = !skid_full_r;
  assign in_tready = en;

  jctp_front u_front (
    .clk   (clk),
    .en    (en),
    .t     (in_tdata[31:0]),
    .eq    (in_tdata[37:32] == in_tdata[43:38]),
    .n     (n_r),
    .c_out (chain[0])
  );

  // series cells, one term each
  for (genvar i = 0; i < jctp_pkg::NUM_TERMS; i++) begin : g_cell
    jctp_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (4'(i + 1)),
      .c_in  (chain[i]),
      .c_out (chain[i + 1])
    );
  end

  jctp_back u_back (
    .clk  (clk),
    .en   (en),
    .n    (n_r),
    .c_in (chain[jctp_pkg::NUM_TERMS]),
    .res  (res)
  );

  // valid flags alongside the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_tvalid};
    end
  end

  assign take   = out_valid_r && out_tready;
  assign arrive = en && vld_r[LAST];

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (arrive) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (take) begin
      if (skid_full_r) begin
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arrive) begin
      if (!out_valid_r || take) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end else if (take && skid_full_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.d2, out_data_r.d1, out_data_r.p};

  `JCTP_ASSERT_SAME(a_skid_has_out, skid_full_r, out_valid_r, "skid full with empty output")
  `JCTP_ASSERT_NEXT(a_skid_holds, skid_full_r && !out_tready, skid_full_r, "skid lost a result")
  `JCTP_ASSERT_NEXT(a_skid_fills, arrive && out_valid_r && !out_tready, skid_full_r,
    "arriving result dropped")

endmodule

/* sv/jctp_div.sv */
// floor(v / m) for m in 1..64: reciprocal product, then one correction
module jctp_div (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] v,
  input  logic [6:0]  m,
  output logic [32:0] q
);

  logic [66:0] prod;
  logic [32:0] v_r;
  logic [6:0]  m_r;
  logic [32:0] q0_r;
  logic [39:0] rem;

  // estimate, at most one below the true quotient
  always_comb begin
    prod = 67'(v) * 67'(jctp_pkg::RECIP[m]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= v;
      m_r  <= m;
      q0_r <= prod[65:33];
    end
  end

  // remainder check
  always_comb begin
    rem = 40'(v_r) - 40'(q0_r) * 40'(m_r);
    q   = q0_r + 33'(rem >= 40'(m_r));
  end

endmodule

/* sv/jctp_front.sv */
// time scaling by n/(n-1) and range reduction by ln2
module jctp_front (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        t,
  input  logic               eq,
  input  logic [6:0]         n,
  output jctp_pkg::exp_t     c_out
);

  logic [32:0] q;
  logic [31:0] t1_r;
  logic        eq1_r;
  logic [33:0] x24_r;
  logic        eq2_r;
  logic [41:0] xw;
  logic [42:0] kp;
  logic [36:0] xl_r;
  logic [5:0]  k0_r;
  logic        big_r;
  logic        eq3_r;
  logic [37:0] r0;
  logic        bump;
  logic [5:0]  k_sel;
  logic [37:0] r_sel;
  jctp_pkg::exp_t c_nxt;
  jctp_pkg::exp_t c_r;

  // t / (n-1)
  jctp_div u_div (
    .clk (clk),
    .en  (en),
    .v   (33'(t)),
    .m   (n - 7'd1),
    .q   (q)
  );

  // k estimate from the scaled time
  always_comb begin
    xw = {x24_r, 8'b0};
    kp = 43'(xw[36:0]) * 43'(jctp_pkg::KRCP);
  end

  // remainder after k whole ln2 steps, with one correction
  always_comb begin
    r0    = 38'(xl_r) - 38'(k0_r) * 38'(jctp_pkg::LN2_Q32);
    bump  = r0 >= 38'(jctp_pkg::LN2_Q32);
    k_sel = bump ? k0_r + 6'd1 : k0_r;
    r_sel = bump ? r0 - 38'(jctp_pkg::LN2_Q32) : r0;
    c_nxt.term = jctp_pkg::ONE_Q32;
    c_nxt.sum  = 35'(jctp_pkg::ONE_Q32);
    c_nxt.r    = r_sel[31:0];
    c_nxt.k    = k_sel[4:0];
    c_nxt.zero = big_r;
    c_nxt.eq   = eq3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= t;
      eq1_r <= eq;
      x24_r <= 34'(t1_r) + 34'(q);
      eq2_r <= eq1_r;
      xl_r  <= xw[36:0];
      k0_r  <= kp[42:37];
      big_r <= xw >= 42'(jctp_pkg::LN2_X32);
      eq3_r <= eq2_r;
      c_r   <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

/* sv/jctp_cell.sv */
// one series term: term = floor(floor(term * r / 2^32) / idx), added to or subtracted from the sum
module jctp_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [3:0]     idx,
  input  jctp_pkg::exp_t c_in,
  output jctp_pkg::exp_t c_out
);

  logic [64:0]    prod;
  logic [32:0]    v_r;
  jctp_pkg::exp_t a_r;
  jctp_pkg::exp_t b_r;
  logic [32:0]    q;
  jctp_pkg::exp_t c_nxt;
  jctp_pkg::exp_t c_r;

  always_comb begin
    prod = 65'(c_in.term) * 65'(c_in.r);
  end

  jctp_div u_div (
    .clk (clk),
    .en  (en),
    .v   (v_r),
    .m   ({3'b0, idx}),
    .q   (q)
  );

  // odd terms subtract, even terms add
  always_comb begin
    c_nxt      = b_r;
    c_nxt.term = q;
    c_nxt.sum  = idx[0] ? b_r.sum - 35'(q) : b_r.sum + 35'(q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= prod[64:32];
      a_r <= c_in;
      b_r <= a_r;
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

/* sv/jctp_back.sv */
// exp finish, probability and derivatives
module jctp_back (
  input  logic           clk,
  input  logic           en,
  input  logic [6:0]     n,
  input  jctp_pkg::exp_t c_in,
  output jctp_pkg::res_t res
);

  logic signed [34:0] sum_c;
  logic [32:0] e_nxt;
  logic [32:0] e0_r;
  logic        eq0_r;
  logic [32:0] e1_r;
  logic        eq1_r;
  logic [33:0] peq;
  logic [32:0] pne;
  logic [32:0] pnum;
  logic [32:0] qf;
  logic [32:0] qp;
  logic [32:0] qd1;
  logic [32:0] qg;
  logic [32:0] padd;
  logic [33:0] g2_r;
  logic [30:0] p2_r;
  logic [31:0] d1m2_r;
  logic        eq2_r;
  logic [33:0] g3_r;
  logic [30:0] p3_r;
  logic [31:0] d1m3_r;
  logic        eq3_r;
  logic [31:0] gq;
  jctp_pkg::res_t res_nxt;
  jctp_pkg::res_t res_r;

  // clamp the series sum and scale by 2^-k, or give zero when the zero flag is set
  always_comb begin
    if (c_in.sum < 35'sd0) begin
      sum_c = 35'sd0;
    end else if (c_in.sum > 35'(jctp_pkg::ONE_Q32)) begin
      sum_c = 35'(jctp_pkg::ONE_Q32);
    end else begin
      sum_c = c_in.sum;
    end
    e_nxt = c_in.zero ? 33'd0 : 33'(sum_c[32:0] >> c_in.k);
  end

  // probability numerator before the divide by n
  always_comb begin
    peq  = 34'(n) * 34'(e0_r[1:0]) + 34'(jctp_pkg::ONE_Q32) - 34'(e0_r);
    pne  = jctp_pkg::ONE_Q32 - e0_r;
    pnum = eq0_r ? 33'(peq[33:2]) : 33'(pne[32:2]);
  end

  jctp_div u_div_f (.clk(clk), .en(en), .v(e0_r), .m(n - 7'd1), .q(qf));
  jctp_div u_div_p (.clk(clk), .en(en), .v(pnum), .m(n), .q(qp));
  jctp_div u_div_d1 (.clk(clk), .en(en), .v(33'(e0_r[32:2])), .m(n - 7'd1), .q(qd1));
  jctp_div u_div_g (.clk(clk), .en(en), .v(33'(g2_r[33:2])), .m(n - 7'd1), .q(qg));

  always_comb begin
    padd = (eq1_r ? 33'(e1_r[32:2]) : 33'd0) + qp;
  end

  // sign and saturation of the derivatives
  always_comb begin
    gq        = g3_r[33:2];
    res_nxt.p = p3_r;
    res_nxt.d1 = eq3_r ? 32'd0 - d1m3_r : d1m3_r;
    if (eq3_r) begin
      res_nxt.d2 = gq > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : gq;
    end else begin
      res_nxt.d2 = 32'd0 - qg[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r   <= e_nxt;
      eq0_r  <= c_in.eq;
      e1_r   <= e0_r;
      eq1_r  <= eq0_r;
      g2_r   <= 34'(e1_r) + 34'(qf);
      p2_r   <= padd[30:0];
      d1m2_r <= eq1_r ? 32'(e1_r[32:2]) : qd1[31:0];
      eq2_r  <= eq1_r;
      g3_r   <= g2_r;
      p3_r   <= p2_r;
      d1m3_r <= d1m2_r;
      eq3_r  <= eq2_r;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
